[rtl/assert_macros.svh]
// Assertion macros used by the top level of the INI line tokenizer.
// Depends on nothing; take it in with an include at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ILT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define ILT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

[rtl/ilt_pkg.sv]
// Shared types and constants of the INI line tokenizer.
// Used by the front classifier, the queue, the back serializer and the top level.
package ilt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FIELD_W         = 16;

    localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};

    localparam logic [1:0] KIND_ENTRY    = 2'd0;
    localparam logic [1:0] KIND_SYNTAX   = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } ilt_in_t;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic [FIELD_W-1:0] key_begin;
        logic [FIELD_W-1:0] key_length;
        logic [FIELD_W-1:0] value_begin;
        logic [FIELD_W-1:0] value_length;
        logic [FIELD_W-1:0] line_number;
        logic [FIELD_W-1:0] entry_total;
        logic               run_end;
    } ilt_out_t;

    typedef struct packed {
        logic               first_v;
        ilt_out_t           first_rec;
        logic               done_v;
        logic [FIELD_W-1:0] done_line;
        logic [FIELD_W-1:0] done_total;
    } ilt_qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ilt_qstat_t;

endpackage

[rtl/ilt_front.sv]
// Front classifier: runs the per-byte line parser and forms the records of one byte.
// Depends on ilt_pkg.
module ilt_front #(
    parameter int OFFSET_BITS = ilt_pkg::OFFSET_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  ilt_pkg::ilt_in_t  in_data,
    output logic              push,
    output ilt_pkg::ilt_qent_t push_data
);
    import ilt_pkg::*;

    localparam logic [2:0] PH_LINE    = 3'd0;
    localparam logic [2:0] PH_COMMENT = 3'd1;
    localparam logic [2:0] PH_KEY     = 3'd2;
    localparam logic [2:0] PH_PREEQ   = 3'd3;
    localparam logic [2:0] PH_PREVAL  = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;

    localparam logic [1:0] NL_NONE = 2'd0;
    localparam logic [1:0] NL_CR   = 2'd1;
    localparam logic [1:0] NL_LF   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [OFFSET_BITS-1:0] LIMIT = {OFFSET_BITS{1'b1}};

    logic [2:0]             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [FIELD_W-1:0]     line_reg, line_next;
    logic [1:0]             nl_reg, nl_next;
    logic [OFFSET_BITS-1:0] kstart_reg, kstart_next;
    logic [OFFSET_BITS-1:0] kend_reg, kend_next;
    logic [OFFSET_BITS-1:0] vstart_reg, vstart_next;
    logic [OFFSET_BITS-1:0] vend_reg, vend_next;
    logic [FIELD_W-1:0]     count_reg, count_next;
    logic                   halted_reg, halted_next;

    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   is_blank, is_eol, is_keych;
    logic                   do_key, do_nl, do_eot;
    logic                   emit_entry, emit_err, emit_long;
    logic [1:0]             nl_code;

    assign c       = in_data.text_byte;
    assign pos     = offset_reg;
    assign pos_inc = offset_reg + 1'b1;
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
    assign is_eol   = (c == CH_CR) || (c == CH_LF);
    assign is_keych = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                      (c >= 8'h61 && c <= 8'h7A) || (c == CH_DOT) || (c == CH_UNDER);
    assign nl_code  = (c == CH_CR) ? NL_CR : NL_LF;

    always_comb begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        nl_next     = nl_reg;
        kstart_next = kstart_reg;
        kend_next   = kend_reg;
        vstart_next = vstart_reg;
        vend_next   = vend_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        do_key      = 1'b0;
        do_nl       = 1'b0;
        do_eot      = 1'b0;
        emit_entry  = 1'b0;
        emit_err    = 1'b0;
        emit_long   = 1'b0;

        if (!halted_reg) begin
            if (offset_reg == LIMIT) begin
                emit_long   = 1'b1;
                halted_next = 1'b1;
            end else begin
                offset_next = pos_inc;
                if (c == CH_NUL) begin
                    do_eot = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_LINE: begin
                            if (is_blank) begin
                                phase_next = PH_LINE;
                            end else if (c == CH_HASH || c == CH_SEMI) begin
                                phase_next = PH_COMMENT;
                            end else if (is_eol) begin
                                do_nl = 1'b1;
                            end else begin
                                kstart_next = pos;
                                kend_next   = pos;
                                do_key      = 1'b1;
                            end
                        end
                        PH_COMMENT: begin
                            do_nl = is_eol;
                        end
                        PH_KEY: begin
                            do_key = 1'b1;
                        end
                        PH_PREEQ: begin
                            if (c == CH_EQ) begin
                                vstart_next = pos_inc;
                                vend_next   = pos_inc;
                                phase_next  = PH_PREVAL;
                            end else if (!is_blank) begin
                                emit_err = 1'b1;
                            end
                        end
                        PH_PREVAL: begin
                            if (is_blank) begin
                                vstart_next = pos_inc;
                                vend_next   = pos_inc;
                            end else if (is_eol) begin
                                emit_entry = 1'b1;
                                do_nl      = 1'b1;
                            end else begin
                                vstart_next = pos;
                                vend_next   = pos_inc;
                                phase_next  = PH_VALUE;
                            end
                        end
                        default: begin
                            if (is_eol) begin
                                emit_entry = 1'b1;
                                do_nl      = 1'b1;
                            end else if (!is_blank) begin
                                vend_next = pos_inc;
                            end
                        end
                    endcase
                end
            end
        end

        if (do_key) begin
            if (is_keych) begin
                kend_next  = pos_inc;
                phase_next = PH_KEY;
            end else if (is_blank) begin
                phase_next = PH_PREEQ;
            end else if (c == CH_EQ) begin
                vstart_next = pos_inc;
                vend_next   = pos_inc;
                phase_next  = PH_PREVAL;
            end else begin
                emit_err = 1'b1;
            end
        end

        if (do_nl) begin
            if (nl_reg == NL_NONE) begin
                nl_next = nl_code;
            end
            if (nl_next == nl_code && line_reg != COUNT_MAX) begin
                line_next = line_reg + 1'b1;
            end
            phase_next = PH_LINE;
        end

        if (emit_err) begin
            halted_next = 1'b1;
        end

        if (in_data.final_byte && !halted_next) begin
            do_eot = 1'b1;
        end

        if (do_eot) begin
            if (phase_next == PH_KEY || phase_next == PH_PREEQ) begin
                emit_err = 1'b1;
            end else if (phase_next == PH_PREVAL || phase_next == PH_VALUE) begin
                emit_entry = 1'b1;
            end
            halted_next = 1'b1;
        end

        if (emit_entry && count_reg != COUNT_MAX) begin
            count_next = count_reg + 1'b1;
        end

        push_data.first_v = emit_entry || emit_err || emit_long;
        push_data.first_rec.record_kind  = emit_entry ? KIND_ENTRY :
                                           emit_err   ? KIND_SYNTAX : KIND_TOO_LONG;
        push_data.first_rec.key_begin    = emit_entry ? FIELD_W'(kstart_next) : '0;
        push_data.first_rec.key_length   =
            emit_entry ? FIELD_W'(kend_next - kstart_next) : '0;
        push_data.first_rec.value_begin  = emit_entry ? FIELD_W'(vstart_next) : '0;
        push_data.first_rec.value_length =
            emit_entry ? FIELD_W'(vend_next - vstart_next) : '0;
        push_data.first_rec.line_number  = line_reg;
        push_data.first_rec.entry_total  = count_next;
        push_data.first_rec.run_end      = 1'b0;
        push_data.done_v     = in_data.final_byte;
        push_data.done_line  = line_next;
        push_data.done_total = count_next;

        // start the next file from reset state
        if (in_data.final_byte) begin
            phase_next  = PH_LINE;
            offset_next = '0;
            line_next   = FIELD_W'(1);
            nl_next     = NL_NONE;
            kstart_next = '0;
            kend_next   = '0;
            vstart_next = '0;
            vend_next   = '0;
            count_next  = '0;
            halted_next = 1'b0;
        end
    end

    assign push = take && (push_data.first_v || push_data.done_v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LINE;
            offset_reg <= '0;
            line_reg   <= FIELD_W'(1);
            nl_reg     <= NL_NONE;
            kstart_reg <= '0;
            kend_reg   <= '0;
            vstart_reg <= '0;
            vend_reg   <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end else if (take) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            nl_reg     <= nl_next;
            kstart_reg <= kstart_next;
            kend_reg   <= kend_next;
            vstart_reg <= vstart_next;
            vend_reg   <= vend_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[rtl/ilt_queue.sv]
// Short queue between the front classifier and the back serializer.
// Depends on ilt_pkg.
module ilt_queue #(
    parameter int DEPTH = ilt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ilt_pkg::ilt_qent_t  push_data,
    input  logic                pop,
    output ilt_pkg::ilt_qent_t  head,
    output ilt_pkg::ilt_qstat_t stat
);
    import ilt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ilt_qent_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 do_push, do_pop;

    assign stat.full  = (fill_reg == CNT_W'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/ilt_back.sv]
// Back serializer: turns each queued byte result into one or two output records.
// Depends on ilt_pkg.
module ilt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ilt_pkg::ilt_qent_t  head,
    input  ilt_pkg::ilt_qstat_t stat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ilt_pkg::ilt_out_t   m_data
);
    import ilt_pkg::*;

    logic     valid_reg, valid_next;
    logic     half_reg, half_next;
    ilt_out_t data_reg, data_next;
    logic     load;

    assign load = !valid_reg || m_ready;

    always_comb begin
        pop        = 1'b0;
        valid_next = valid_reg;
        half_next  = half_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = !stat.empty;
            if (!stat.empty) begin
                if (head.first_v && !half_reg) begin
                    data_next         = head.first_rec;
                    data_next.run_end = !head.done_v;
                    if (head.done_v) begin
                        half_next = 1'b1;
                    end else begin
                        pop = 1'b1;
                    end
                end else begin
                    data_next.record_kind  = KIND_DONE;
                    data_next.key_begin    = '0;
                    data_next.key_length   = '0;
                    data_next.value_begin  = '0;
                    data_next.value_length = '0;
                    data_next.line_number  = head.done_line;
                    data_next.entry_total  = head.done_total;
                    data_next.run_end      = 1'b1;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[rtl/ini_line_tokenizer_core.sv]
// Top level of the INI line tokenizer: front classifier, queue, back serializer.
// Depends on ilt_pkg, ilt_front, ilt_queue, ilt_back and assert_macros.svh.
//
//   channel   direction  ports                       payload
//   s_        in         s_valid s_ready s_data      text_byte, final_byte
//   m_        out        m_valid m_ready m_data      one record per transaction
//
// One byte is accepted per cycle while the queue has room; the parser state
// updates in the cycle of acceptance. A record passes through the queue into the
// output register, which loads when it is empty or being taken, and stays there
// until taken; a final byte with a pending record yields two records. Queue depth
// bounds how many record-producing bytes run ahead of a stalled output.
// Reset is synchronous and active low; no clearing pass.
`include "assert_macros.svh"

module ini_line_tokenizer_core #(
    parameter int OFFSET_BITS = ilt_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = ilt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ilt_pkg::ilt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ilt_pkg::ilt_out_t m_data
);
    import ilt_pkg::*;

    logic       take;
    logic       push;
    logic       pop;
    ilt_qent_t  push_data;
    ilt_qent_t  head;
    ilt_qstat_t qstat;

    assign s_ready = !qstat.full;
    assign take    = s_valid && s_ready;

    ilt_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .in_data  (s_data),
        .push     (push),
        .push_data(push_data)
    );

    ilt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    ilt_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .head   (head),
        .stat   (qstat),
        .pop    (pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    `ILT_ASSERT_NOW(a_done_ends_run, aclk, aresetn,
        m_valid && m_data.record_kind == KIND_DONE, m_data.run_end)
    `ILT_ASSERT_NOW(a_nonentry_zero, aclk, aresetn,
        m_valid && m_data.record_kind != KIND_ENTRY,
        m_data.key_begin == '0 && m_data.key_length == '0 && m_data.value_length == '0)
    `ILT_ASSERT_NOW(a_entry_counted, aclk, aresetn,
        m_valid && m_data.record_kind == KIND_ENTRY, m_data.entry_total != '0)
    `ILT_ASSERT_NEXT(a_pop_clears_full, aclk, aresetn,
        pop && !push, !qstat.full)

endmodule

[tb/ini_line_tokenizer_core_tb.sv]
// Self-checking testbench for ini_line_tokenizer_core: random INI text in, records checked
// against a built-in tokenizer predictor. Depends on ilt_pkg and the core RTL only.
module ini_line_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE, PH_COMMENT, PH_KEY, PH_PREEQ, PH_PREVAL, PH_VALUE
    } tok_phase_e;

    typedef enum logic [1:0] {NL_UNSET, NL_CR, NL_LF} nl_kind_e;

    localparam logic [31:0] OFS_LIMIT   = (32'd1 << OFFSET_BITS_DEF) - 32'd1;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_CYCLES = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ilt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ilt_out_t m_data;

    ini_line_tokenizer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // tokenizer state
    tok_phase_e  tk_phase;
    nl_kind_e    tk_nl;
    logic [31:0] tk_ofs;
    logic [31:0] tk_key_start;
    logic [31:0] tk_key_end;
    logic [31:0] tk_val_start;
    logic [31:0] tk_val_end;
    logic [15:0] tk_line;
    logic [15:0] tk_entries;
    bit          tk_halted;

    ilt_out_t byte_recs[$];
    ilt_out_t expect_recs[$];
    ilt_out_t want_rec;
    ilt_in_t  feed_q[$];
    logic [7:0] file_text[$];

    int send_idle = 0;
    int recv_idle = 0;
    int fail_cnt = 0;
    int bytes_queued = 0;
    int bytes_in = 0;
    int stall_cycles = 0;
    int kind_cnt[4] = '{0, 0, 0, 0};

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_eol(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit is_keych(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CH_DOT || c == CH_UNDER;
    endfunction

    function automatic void tok_reset();
        tk_phase     = PH_LINE;
        tk_nl        = NL_UNSET;
        tk_ofs       = '0;
        tk_key_start = '0;
        tk_key_end   = '0;
        tk_val_start = '0;
        tk_val_end   = '0;
        tk_line      = 16'd1;
        tk_entries   = '0;
        tk_halted    = 1'b0;
    endfunction

    function automatic void add_rec(input logic [1:0] kind, input logic [31:0] kb,
                                    input logic [31:0] kl, input logic [31:0] vb,
                                    input logic [31:0] vl);
        ilt_out_t r;
        r.record_kind  = kind;
        r.key_begin    = kb[15:0];
        r.key_length   = kl[15:0];
        r.value_begin  = vb[15:0];
        r.value_length = vl[15:0];
        r.line_number  = tk_line;
        r.entry_total  = tk_entries;
        r.run_end      = 1'b0;
        byte_recs.push_back(r);
    endfunction

    function automatic void add_entry();
        if (tk_entries != COUNT_MAX)
            tk_entries++;
        add_rec(KIND_ENTRY, tk_key_start, tk_key_end - tk_key_start,
                tk_val_start, tk_val_end - tk_val_start);
    endfunction

    function automatic void add_syntax_error();
        add_rec(KIND_SYNTAX, '0, '0, '0, '0);
        tk_halted = 1'b1;
    endfunction

    function automatic void take_eol(input logic [7:0] c);
        nl_kind_e k;
        k = (c == CH_CR) ? NL_CR : NL_LF;
        if (tk_nl == NL_UNSET)
            tk_nl = k;
        if (tk_nl == k && tk_line != COUNT_MAX)
            tk_line++;
        tk_phase = PH_LINE;
    endfunction

    function automatic void end_text();
        if (tk_phase == PH_KEY || tk_phase == PH_PREEQ)
            add_syntax_error();
        else if (tk_phase == PH_PREVAL || tk_phase == PH_VALUE)
            add_entry();
        tk_halted = 1'b1;
    endfunction

    function automatic void open_value(input logic [31:0] pos);
        tk_val_start = pos + 1;
        tk_val_end   = pos + 1;
        tk_phase     = PH_PREVAL;
    endfunction

    function automatic void key_char_step(input logic [7:0] c, input logic [31:0] pos);
        if (is_keych(c)) begin
            tk_key_end = pos + 1;
            tk_phase   = PH_KEY;
        end else if (is_blank(c)) begin
            tk_phase = PH_PREEQ;
        end else if (c == CH_EQ) begin
            open_value(pos);
        end else begin
            add_syntax_error();
        end
    endfunction

    function automatic void text_step(input logic [7:0] c);
        logic [31:0] pos;
        pos = tk_ofs;
        tk_ofs++;
        if (c == CH_NUL) begin
            end_text();
            return;
        end
        case (tk_phase)
            PH_LINE: begin
                if (c == CH_HASH || c == CH_SEMI) begin
                    tk_phase = PH_COMMENT;
                end else if (is_eol(c)) begin
                    take_eol(c);
                end else if (!is_blank(c)) begin
                    tk_key_start = pos;
                    tk_key_end   = pos;
                    key_char_step(c, pos);
                end
            end
            PH_COMMENT: begin
                if (is_eol(c))
                    take_eol(c);
            end
            PH_KEY: key_char_step(c, pos);
            PH_PREEQ: begin
                if (c == CH_EQ)
                    open_value(pos);
                else if (!is_blank(c))
                    add_syntax_error();
            end
            PH_PREVAL: begin
                if (is_blank(c)) begin
                    tk_val_start = pos + 1;
                    tk_val_end   = pos + 1;
                end else if (is_eol(c)) begin
                    add_entry();
                    take_eol(c);
                end else begin
                    tk_val_start = pos;
                    tk_val_end   = pos + 1;
                    tk_phase     = PH_VALUE;
                end
            end
            default: begin
                if (is_eol(c)) begin
                    add_entry();
                    take_eol(c);
                end else if (!is_blank(c)) begin
                    tk_val_end = pos + 1;
                end
            end
        endcase
    endfunction

    function automatic void tokenize_byte(input ilt_in_t item);
        byte_recs.delete();
        if (!tk_halted) begin
            if (tk_ofs >= OFS_LIMIT) begin
                add_rec(KIND_TOO_LONG, '0, '0, '0, '0);
                tk_halted = 1'b1;
            end else begin
                text_step(item.text_byte);
            end
        end
        if (item.final_byte) begin
            if (!tk_halted)
                end_text();
            add_rec(KIND_DONE, '0, '0, '0, '0);
            tok_reset();
        end
        if (byte_recs.size() > 0)
            byte_recs[byte_recs.size() - 1].run_end = 1'b1;
        foreach (byte_recs[i])
            expect_recs.push_back(byte_recs[i]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // text generation
    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] pick_key_char();
        int n;
        n = $urandom_range(63);
        if (n < 10)
            return "0" + 8'(n);
        if (n < 36)
            return "A" + 8'(n - 10);
        if (n < 62)
            return "a" + 8'(n - 36);
        return n[0] ? CH_DOT : CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_value_byte();
        logic [7:0] c;
        do begin
            if ($urandom_range(3) != 0)
                c = 8'($urandom_range(32, 126));
            else
                c = 8'($urandom_range(1, 255));
        end while (is_eol(c));
        return c;
    endfunction

    task automatic put_blanks(input int maxn);
        repeat ($urandom_range(maxn)) file_text.push_back(pick_blank());
    endtask

    task automatic put_eol(input int style);
        int s;
        s = (style == 3) ? $urandom_range(2) : style;
        if (s == 1 || s == 2)
            file_text.push_back(CH_CR);
        if (s == 0 || s == 2)
            file_text.push_back(CH_LF);
    endtask

    task automatic put_line(input int style);
        int sel;
        logic [7:0] c;
        sel = $urandom_range(99);
        put_blanks(2);
        if (sel < 60) begin
            repeat ($urandom_range(6)) file_text.push_back(pick_key_char());
            put_blanks(2);
            file_text.push_back(CH_EQ);
            put_blanks(2);
            repeat ($urandom_range(8)) file_text.push_back(pick_value_byte());
            put_blanks(2);
        end else if (sel < 75) begin
            file_text.push_back($urandom_range(1) ? CH_HASH : CH_SEMI);
            repeat ($urandom_range(8)) file_text.push_back(pick_value_byte());
        end else if (sel >= 82 && sel < 94) begin
            repeat ($urandom_range(1, 4)) file_text.push_back(pick_key_char());
            case ($urandom_range(2))
                0: put_blanks(2);
                1: begin
                    do c = pick_value_byte();
                    while (is_keych(c) || is_blank(c) || c == CH_EQ);
                    file_text.push_back(c);
                end
                default: begin
                    file_text.push_back(pick_blank());
                    file_text.push_back(pick_key_char());
                end
            endcase
        end else if (sel >= 94) begin
            repeat ($urandom_range(1, 4)) file_text.push_back(8'($urandom_range(1, 255)));
        end
        put_eol(style);
    endtask

    task automatic gen_file(input int nlines);
        int style;
        int ending;
        style  = $urandom_range(3);
        ending = $urandom_range(7);
        file_text.delete();
        repeat (nlines) put_line(style);
        // cut the file short inside a line
        if (ending >= 1 && ending <= 3)
            repeat ($urandom_range(1, 3))
                if (file_text.size() > 1)
                    void'(file_text.pop_back());
        if (ending == 0 || ending == 4) begin
            file_text.push_back(CH_NUL);
            repeat ($urandom_range(3)) file_text.push_back(8'($urandom_range(255)));
        end
        if (file_text.size() == 0)
            file_text.push_back(pick_key_char());
    endtask

    task automatic send_file();
        foreach (file_text[i]) begin
            ilt_in_t item;
            item.text_byte  = file_text[i];
            item.final_byte = (i == file_text.size() - 1);
            feed_q.push_back(item);
        end
        bytes_queued += file_text.size();
    endtask

    task automatic send_random(input int nbytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < nbytes) begin
            gen_file($urandom_range(1, 6));
            send_file();
        end
    endtask

    task automatic wait_idle();
        while (feed_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (expect_recs.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            tok_reset();
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                tokenize_byte(s_data);
                bytes_in++;
            end
            if (feed_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_valid <= 1'b1;
                s_data  <= feed_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (m_valid && m_ready) begin
                if (expect_recs.size() == 0) begin
                    $error("record with no expected transaction: kind %0d, line %0d",
                           m_data.record_kind, m_data.line_number);
                    fail_cnt++;
                end else begin
                    want_rec = expect_recs.pop_front();
                    kind_cnt[want_rec.record_kind]++;
                    check_field("record_kind", 16'(want_rec.record_kind),
                                16'(m_data.record_kind));
                    check_field("key_begin", want_rec.key_begin, m_data.key_begin);
                    check_field("key_length", want_rec.key_length, m_data.key_length);
                    check_field("value_begin", want_rec.value_begin, m_data.value_begin);
                    check_field("value_length", want_rec.value_length, m_data.value_length);
                    check_field("line_number", want_rec.line_number, m_data.line_number);
                    check_field("entry_total", want_rec.entry_total, m_data.entry_total);
                    check_field("run_end", 16'(want_rec.run_end), 16'(m_data.run_end));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        while (!aresetn)
            @(posedge aclk);

        send_idle = 10;
        recv_idle = 87;
        file_text = '{CH_SPACE, "a", CH_EQ, CH_HIGH, CH_SPACE, CH_CR, CH_HASH, "x", CH_LF,
                      CH_EQ, CH_CR, "k", CH_LF, "z", CH_NUL};
        send_file();
        file_text = '{"k", CH_NUL, "q"};
        send_file();
        file_text = '{"b", CH_SPACE, CH_EQ, CH_SPACE, "v"};
        send_file();
        file_text = '{CH_NUL};
        send_file();
        send_random(550);
        wait_idle();

        send_idle = 87;
        recv_idle = 10;
        send_random(550);
        wait_idle();

        send_idle = 0;
        recv_idle = 0;
        send_random(200);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expect_recs.size() != 0) begin
            $error("%0d expected records never arrived", expect_recs.size());
            fail_cnt++;
        end
        $display("Covered %0d bytes in %0d files: %0d entries, %0d syntax errors, %0d too-long",
                 bytes_in, kind_cnt[KIND_DONE], kind_cnt[KIND_ENTRY], kind_cnt[KIND_SYNTAX],
                 kind_cnt[KIND_TOO_LONG]);
        $display("Idle mixes: sender-light/receiver-heavy, the reverse, and none; %0d errors",
                 fail_cnt);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ilt_pkg.sv
rtl/ilt_front.sv
rtl/ilt_queue.sv
rtl/ilt_back.sv
rtl/ini_line_tokenizer_core.sv
tb/ini_line_tokenizer_core_tb.sv
